// ===== hw/rtl/edt_pkg.sv =====
package edt_pkg;

  // Error codes reported with every result.
  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_SYMBOL = 2'd1;
  localparam logic [1:0] ERR_CHECK  = 2'd2;

  // Quantity carried by a good frame.
  localparam logic [1:0] KIND_ERPM    = 2'd0;
  localparam logic [1:0] KIND_VOLTAGE = 2'd1;
  localparam logic [1:0] KIND_CURRENT = 2'd2;
  localparam logic [1:0] KIND_TEMP    = 2'd3;

  localparam int unsigned SYM_COUNT = 4;
  localparam int unsigned SYM_W     = 5;
  localparam int unsigned VALUE_W   = 12;

  // CRC-4 (x^4 + x^2 + x + 1) contribution of each value bit, index = bit position.
  localparam logic [3:0] CRC_COL [VALUE_W] = '{
    4'h1, 4'h2, 4'h4, 4'h8, 4'h7, 4'hE, 4'hB, 4'h1, 4'h2, 4'h4, 4'h8, 4'h7
  };

  // Outcome of decoding one frame.
  typedef struct packed {
    logic [1:0]         err;
    logic [1:0]         kind;
    logic [VALUE_W-1:0] value;
    logic [3:0]         check;
  } decode_t;

  // Per-motor record held in the state memory.
  typedef struct packed {
    logic [10:0] erpm;
    logic [11:0] voltage;
    logic [10:0] current;
    logic [7:0]  temperature;
    logic [3:0]  check;
  } held_rec_t;

  // GCR symbol to nibble; bit 4 set marks a symbol with no code.
  function automatic logic [4:0] gcr_decode(input logic [SYM_W-1:0] sym);
    logic [4:0] res;
    case (sym)
      5'd9:    res = 5'h09;
      5'd10:   res = 5'h0A;
      5'd11:   res = 5'h0B;
      5'd13:   res = 5'h0D;
      5'd14:   res = 5'h0E;
      5'd15:   res = 5'h0F;
      5'd18:   res = 5'h02;
      5'd19:   res = 5'h03;
      5'd21:   res = 5'h05;
      5'd22:   res = 5'h06;
      5'd23:   res = 5'h07;
      5'd25:   res = 5'h00;
      5'd26:   res = 5'h08;
      5'd27:   res = 5'h01;
      5'd29:   res = 5'h04;
      5'd30:   res = 5'h0C;
      default: res = 5'h10;
    endcase
    return res;
  endfunction

  // Serial CRC-4 over the value, MSB first, folded into an XOR of columns.
  function automatic logic [3:0] crc4(input logic [VALUE_W-1:0] value);
    logic [3:0] acc;
    acc = 4'h0;
    for (int k = 0; k < VALUE_W; k++) begin
      if (value[k]) begin
        acc = acc ^ CRC_COL[k];
      end
    end
    return acc;
  endfunction

endpackage

// ===== hw/rtl/edt_frame_decode.sv =====
module edt_frame_decode
  import edt_pkg::*;
(
  input  logic [20:0] raw_frame,
  output decode_t     dec
);

  logic [4:0]  nib   [SYM_COUNT];
  logic [15:0] word;
  logic        bad_sym;
  logic [VALUE_W-1:0] value;
  logic [3:0]  check;

  // Look up the four symbols; the first one sits in the top bits.
  always_comb begin
    for (int i = 0; i < SYM_COUNT; i++) begin
      nib[i] = gcr_decode(raw_frame[20 - SYM_W * i -: SYM_W]);
    end
    bad_sym = nib[0][4] | nib[1][4] | nib[2][4] | nib[3][4];
    word    = {nib[0][3:0], nib[1][3:0], nib[2][3:0], nib[3][3:0]};
    value   = word[15:4];
    check   = word[3:0];
  end

  // Error priority, then the value range picks the quantity.
  always_comb begin
    dec.value = value;
    dec.check = check;
    dec.kind  = KIND_ERPM;
    if (bad_sym) begin
      dec.err = ERR_SYMBOL;
    end else if (crc4(value) != check) begin
      dec.err = ERR_CHECK;
    end else begin
      dec.err = ERR_OK;
      if (!value[11]) begin
        dec.kind = KIND_ERPM;
      end else if (!value[10]) begin
        dec.kind = KIND_VOLTAGE;
      end else if (!value[9]) begin
        dec.kind = KIND_CURRENT;
      end else begin
        dec.kind = KIND_TEMP;
      end
    end
  end

endmodule

// ===== hw/rtl/edt_telemetry_decoder.sv =====
// Channel | Direction | Ports                         | Contents
// in      | sink      | in_tvalid/in_tready/in_tdata  | motor index, raw 21-bit frame
// out     | source    | out_tvalid/out_tready/out_*   | status and held values of the motor
//
// One frame is taken every cycle while the sink does not stall; a result passes
// through stage 1 and the output register before it is offered.
// The frame is decoded in the transfer cycle while the motor's record is read from
// the state memory; stage 1 merges and writes it back when it advances, with a
// forward path for a frame of the same motor right behind. The output register holds a
// result while the sink stalls, so the input keeps going until both stages are full.
// Reset clears the pipeline and the per-motor valid bits; no clearing pass.
module edt_telemetry_decoder
  import edt_pkg::*;
#(
  parameter int MOTOR_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] motor_index, [22:2] raw_frame, [23] zero
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] frame_ok, [2:1] error_code, [13:3] erpm_out, [25:14] voltage_cv_out,
  // [36:26] current_ca_out, [44:37] temperature_out, [48:45] check_out,
  // [49] have_data, [55:50] zero
  output logic [55:0] out_tdata,
  // [1:0] quantity_kind
  output logic [1:0]  out_tuser
);

  localparam int ADDR_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  logic [1:0]        in_motor;
  logic [20:0]       in_frame;
  logic [4:0]        in_motor_ext;
  logic              in_in_range;
  logic [ADDR_W-1:0] in_addr;
  logic              in_xfer;
  decode_t           in_dec;

  logic              s1_valid_r;
  decode_t           s1_dec_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_in_range_r;

  held_rec_t         mem [MOTOR_COUNT];
  held_rec_t         rd_r;
  logic [MOTOR_COUNT-1:0] valid_r;
  logic              fwd_hit_r;
  held_rec_t         fwd_rec_r;

  held_rec_t         old_rec;
  held_rec_t         merged;
  logic              good;
  logic              have;
  logic              adv;
  logic              mem_we;

  logic              out_valid_r;
  logic [55:0]       out_tdata_r;
  logic [1:0]        out_tuser_r;

  // Input fields and address of the motor record.
  assign in_motor     = in_tdata[1:0];
  assign in_frame     = in_tdata[22:2];
  assign in_motor_ext = {3'b000, in_motor};
  assign in_in_range  = in_motor_ext < 5'(MOTOR_COUNT);
  assign in_addr      = in_in_range ? in_motor_ext[ADDR_W-1:0] : '0;

  edt_frame_decode u_decode (
    .raw_frame (in_frame),
    .dec       (in_dec)
  );

  // Handshake: stage 1 moves on whenever the output register is free or drains.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign in_xfer   = in_tvalid && in_tready;

  // Stage 1 control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_dec_r      <= in_dec;
      s1_addr_r     <= in_addr;
      s1_in_range_r <= in_in_range;
    end
  end

  // State memory: read at transfer, write back from stage 1.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[s1_addr_r] <= merged;
    end
    if (in_xfer) begin
      rd_r <= mem[in_addr];
    end
  end

  // Valid bit per motor; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[s1_addr_r] <= 1'b1;
    end
  end

  // Forward the record written in the same cycle the next frame reads it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (in_xfer) begin
      fwd_hit_r <= mem_we && in_in_range && (in_addr == s1_addr_r);
    end else if (s1_valid_r && adv) begin
      fwd_hit_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fwd_rec_r <= merged;
    end
  end

  // Merge the decoded quantity into the motor record.
  always_comb begin
    if (fwd_hit_r) begin
      old_rec = fwd_rec_r;
    end else if (valid_r[s1_addr_r]) begin
      old_rec = rd_r;
    end else begin
      old_rec = '0;
    end
    good   = s1_in_range_r && (s1_dec_r.err == ERR_OK);
    merged = old_rec;
    if (good) begin
      merged.check = s1_dec_r.check;
      case (s1_dec_r.kind)
        KIND_ERPM:    merged.erpm        = s1_dec_r.value[10:0];
        KIND_VOLTAGE: merged.voltage     = {s1_dec_r.value[9:0], 2'b00};
        KIND_CURRENT: merged.current     = {s1_dec_r.value[8:0], 2'b00};
        default:      merged.temperature = s1_dec_r.value[8:1];
      endcase
    end
    have   = valid_r[s1_addr_r] || good;
    mem_we = s1_valid_r && adv && good;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && adv) begin
      out_tuser_r <= s1_dec_r.kind;
      if (s1_in_range_r) begin
        out_tdata_r <= {6'b0, have, merged.check, merged.temperature, merged.current,
                        merged.voltage, merged.erpm, s1_dec_r.err, good};
      end else begin
        out_tdata_r <= {6'b0, 47'b0, s1_dec_r.err, 1'b0};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef NO_ASSERTIONS
  a_ok_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tdata_r[0] |-> out_tdata_r[2:1] == ERR_OK && out_tdata_r[49])
    else $error("good frame reported with an error or without data");

  a_error_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tdata_r[2:1] != ERR_OK |-> out_tuser_r == KIND_ERPM)
    else $error("error result carries a quantity kind");

  a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> s1_valid_r)
    else $error("forwarded record without a frame in stage 1");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> valid_r[$past(s1_addr_r)])
    else $error("record written without its valid bit");
`endif

endmodule
